### sv/usv_pkg.sv
// shared types and constants of the uv sphere vertex generator
package usv_pkg;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_RADIUS      = 2'd0;
    localparam logic [1:0] CFG_SECTOR_STEP = 2'd1;
    localparam logic [1:0] CFG_STACK_STEP  = 2'd2;

    localparam int CFG_W  = 16;
    localparam int X_W    = 17;   // quarter-turn argument, 0 .. 65536
    localparam int MAG_W  = 15;   // q1.14 magnitude, 0 .. 16384
    localparam int POS_W  = 17;
    localparam int NORM_W = 16;

    // polynomial coefficients, q16
    localparam logic [16:0] SIN_A = 17'd102944;
    localparam logic [15:0] SIN_B = 16'd42048;
    localparam logic [12:0] SIN_C = 13'd4640;

    localparam logic [X_W-1:0]   X_FULL   = 17'd65536;
    localparam logic [MAG_W-1:0] MAG_ONE  = 15'd16384;

    // load enables of the four polynomial stages
    typedef struct packed {
        logic sq;
        logic c_term;
        logic b_term;
        logic a_term;
    } t_sin_en;

endpackage

### sv/usv_in_if.sv
// request channel carrying the stack and sector indexes
interface usv_in_if #(parameter int INDEX_BITS = 10);
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] stack_index;
    logic [INDEX_BITS-1:0] sector_index;

    modport source (output valid, output stack_index, output sector_index, input ready);
    modport sink   (input valid, input stack_index, input sector_index, output ready);
endinterface

### sv/usv_out_if.sv
// result channel carrying vertex position and normal
interface usv_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [usv_pkg::POS_W-1:0]  pos_x;
    logic signed [usv_pkg::POS_W-1:0]  pos_y;
    logic signed [usv_pkg::POS_W-1:0]  pos_z;
    logic signed [usv_pkg::NORM_W-1:0] norm_x;
    logic signed [usv_pkg::NORM_W-1:0] norm_y;
    logic signed [usv_pkg::NORM_W-1:0] norm_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output norm_x, output norm_y, output norm_z, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input norm_x, input norm_y, input norm_z, output ready);
endinterface

### sv/usv_sine.sv
// four-stage pipelined quarter-turn sine polynomial
module usv_sine (
    input  logic                        i_clk,
    input  usv_pkg::t_sin_en            i_en,
    input  logic [usv_pkg::X_W-1:0]     i_x,
    output logic [usv_pkg::MAG_W-1:0]   o_mag
);
    logic [usv_pkg::X_W-1:0] r_x_a, r_x2_a;
    logic [15:0]             r_t_b;
    logic [usv_pkg::X_W-1:0] r_x_b, r_x2_b;
    logic [16:0]             r_t_c;
    logic [usv_pkg::X_W-1:0] r_x_c;
    logic [usv_pkg::MAG_W-1:0] r_mag;

    logic [33:0] n_sq;
    logic [29:0] n_cx;
    logic [32:0] n_bx;
    logic [33:0] n_ax;
    logic [16:0] n_s;
    logic [15:0] n_r;

    always_comb begin
        n_sq = 34'(i_x) * 34'(i_x);
        n_cx = 30'(usv_pkg::SIN_C) * 30'(r_x2_a);
        n_bx = 33'(r_t_b) * 33'(r_x2_b);
        n_ax = 34'(r_t_c) * 34'(r_x_c);
        n_s  = n_ax[32:16];
        n_r  = 16'((18'(n_s) + 18'd2) >> 2);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.sq) begin
            r_x_a  <= i_x;
            r_x2_a <= n_sq[32:16];
        end
        if (i_en.c_term) begin
            r_t_b  <= usv_pkg::SIN_B - 16'(n_cx[29:16]);
            r_x_b  <= r_x_a;
            r_x2_b <= r_x2_a;
        end
        if (i_en.b_term) begin
            r_t_c <= usv_pkg::SIN_A - 17'(n_bx[32:16]);
            r_x_c <= r_x_b;
        end
        if (i_en.a_term) begin
            r_mag <= (n_r > 16'(usv_pkg::MAG_ONE)) ? usv_pkg::MAG_ONE : n_r[14:0];
        end
    end

    assign o_mag = r_mag;
endmodule

### sv/uv_sphere_vertex_generator.sv
// top level of the uv sphere vertex generator
//
// i_in carries one request per vertex: a stack index (ring, 0 is the north
// pole) and a sector index (column). o_out returns, for every request and in
// order, the vertex position in q4.12 and its unit normal in q1.14.
// i_cfg_we / i_cfg_index / i_cfg_data write radius (0), sector step (1) and
// stack step (2); write them only while no request is in flight.
//
// one request per cycle sustained while o_out.ready stays high. stage 1
// forms both angles, stages 2 to 5 run four polynomial sine units (up and
// down for each angle), stage 6 maps quadrants and forms the normal products,
// stage 7 scales by the radius into the output register.
//
// every stage holds its own valid bit; a stage loads whenever it is empty
// or the stage after it moves, so bubbles are squeezed out and a stalled
// receiver backs the pipeline up without loss, and the block then holds up to
// seven requests, the one offered at the output included.
// reset (synchronous, active low) clears all valid bits and restores the
// register defaults: radius 1638, both steps 303.
module uv_sphere_vertex_generator #(
    parameter int INDEX_BITS = 10,
    parameter int ANGLE_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [usv_pkg::CFG_W-1:0]   i_cfg_data,
    usv_in_if.sink                      i_in,
    usv_out_if.source                   o_out
);
    localparam int PW = INDEX_BITS + usv_pkg::CFG_W;
    localparam int OW = ANGLE_BITS - 2;
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << OW;

    // configuration registers
    logic [usv_pkg::CFG_W-1:0] r_radius, r_sector_step, r_stack_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius      <= 16'd1638;
            r_sector_step <= 16'd303;
            r_stack_step  <= 16'd303;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                usv_pkg::CFG_RADIUS:      r_radius      <= i_cfg_data;
                usv_pkg::CFG_SECTOR_STEP: r_sector_step <= i_cfg_data;
                usv_pkg::CFG_STACK_STEP:  r_stack_step  <= i_cfg_data;
                default: ;  // unused index is ignored
            endcase
        end
    end

    // pipeline control: stage k loads when empty or when stage k+1 loads
    logic [7:1] r_v;
    logic [8:1] en;

    always_comb begin
        en[8] = o_out.ready;
        for (int k = 7; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign i_in.ready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) r_v[1] <= i_in.valid;
            for (int k = 2; k <= 7; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 1: angles in turns, wrapped to ANGLE_BITS
    logic [PW-1:0]            n_st_prod, n_se_prod;
    logic [PW+ANGLE_BITS-1:0] n_st_ext, n_se_ext;
    logic [ANGLE_BITS-1:0]    r_st_ang, r_se_ang;

    always_comb begin
        n_st_prod = PW'(i_in.stack_index) * PW'(r_stack_step);
        n_se_prod = PW'(i_in.sector_index) * PW'(r_sector_step);
        n_st_ext  = (PW+ANGLE_BITS)'(n_st_prod);
        n_se_ext  = (PW+ANGLE_BITS)'(n_se_prod);
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_st_ang <= QUARTER - n_st_ext[ANGLE_BITS-1:0];
            r_se_ang <= n_se_ext[ANGLE_BITS-1:0];
        end
    end

    // quadrant split: offset scaled to q0.16 of a quarter turn
    logic [OW+17:0]          n_st_sc, n_se_sc;
    logic [usv_pkg::X_W-1:0] n_st_x, n_se_x;

    always_comb begin
        n_st_sc = {r_st_ang[OW-1:0], 18'd0};
        n_se_sc = {r_se_ang[OW-1:0], 18'd0};
        n_st_x  = {1'b0, n_st_sc[OW+17:OW+2]};
        n_se_x  = {1'b0, n_se_sc[OW+17:OW+2]};
    end

    // quadrants ride along with the sine pipeline, stages 2 to 5
    logic [1:0] r_st_q [2:5];
    logic [1:0] r_se_q [2:5];

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_st_q[2] <= r_st_ang[ANGLE_BITS-1 -: 2];
            r_se_q[2] <= r_se_ang[ANGLE_BITS-1 -: 2];
        end
        for (int k = 3; k <= 5; k++) begin
            if (en[k]) begin
                r_st_q[k] <= r_st_q[k-1];
                r_se_q[k] <= r_se_q[k-1];
            end
        end
    end

    usv_pkg::t_sin_en sin_en;
    assign sin_en = '{sq: en[2], c_term: en[3], b_term: en[4], a_term: en[5]};

    logic [usv_pkg::MAG_W-1:0] st_up, st_dn, se_up, se_dn;

    usv_sine u_st_up (.i_clk, .i_en(sin_en), .i_x(n_st_x), .o_mag(st_up));
    usv_sine u_st_dn (.i_clk, .i_en(sin_en), .i_x(usv_pkg::X_FULL - n_st_x),
                      .o_mag(st_dn));
    usv_sine u_se_up (.i_clk, .i_en(sin_en), .i_x(n_se_x), .o_mag(se_up));
    usv_sine u_se_dn (.i_clk, .i_en(sin_en), .i_x(usv_pkg::X_FULL - n_se_x),
                      .o_mag(se_dn));

    // stage 6: quadrant mapping, cos*cos and cos*sin rounded to q1.14
    logic [usv_pkg::MAG_W-1:0] n_sst_m, n_cst_m, n_sse_m, n_cse_m;
    logic                      n_sst_n, n_cst_n, n_sse_n, n_cse_n;
    logic [30:0]               n_nx_p, n_ny_p;

    always_comb begin
        case (r_st_q[5])
            2'd0:    begin n_sst_m = st_up; n_sst_n = 1'b0; n_cst_m = st_dn; n_cst_n = 1'b0; end
            2'd1:    begin n_sst_m = st_dn; n_sst_n = 1'b0; n_cst_m = st_up; n_cst_n = 1'b1; end
            2'd2:    begin n_sst_m = st_up; n_sst_n = 1'b1; n_cst_m = st_dn; n_cst_n = 1'b1; end
            default: begin n_sst_m = st_dn; n_sst_n = 1'b1; n_cst_m = st_up; n_cst_n = 1'b0; end
        endcase
        case (r_se_q[5])
            2'd0:    begin n_sse_m = se_up; n_sse_n = 1'b0; n_cse_m = se_dn; n_cse_n = 1'b0; end
            2'd1:    begin n_sse_m = se_dn; n_sse_n = 1'b0; n_cse_m = se_up; n_cse_n = 1'b1; end
            2'd2:    begin n_sse_m = se_up; n_sse_n = 1'b1; n_cse_m = se_dn; n_cse_n = 1'b1; end
            default: begin n_sse_m = se_dn; n_sse_n = 1'b1; n_cse_m = se_up; n_cse_n = 1'b0; end
        endcase
        n_nx_p = 31'(n_cst_m) * 31'(n_cse_m) + 31'd8192;
        n_ny_p = 31'(n_cst_m) * 31'(n_sse_m) + 31'd8192;
    end

    logic [usv_pkg::MAG_W-1:0] r_nx_m, r_ny_m, r_nz_m;
    logic                      r_nx_n, r_ny_n, r_nz_n;

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_nx_m <= n_nx_p[28:14];
            r_nx_n <= n_cst_n ^ n_cse_n;
            r_ny_m <= n_ny_p[28:14];
            r_ny_n <= n_cst_n ^ n_sse_n;
            r_nz_m <= n_sst_m;
            r_nz_n <= n_sst_n;
        end
    end

    // stage 7: scale by radius, round on magnitudes, apply signs
    logic [31:0] n_px_p, n_py_p, n_pz_p;

    always_comb begin
        n_px_p = 32'(r_nx_m) * 32'(r_radius) + 32'd8192;
        n_py_p = 32'(r_ny_m) * 32'(r_radius) + 32'd8192;
        n_pz_p = 32'(r_nz_m) * 32'(r_radius) + 32'd8192;
    end

    function automatic logic [usv_pkg::POS_W-1:0] signed_pos(input logic [31:0] p,
                                                              input logic neg);
        logic [usv_pkg::POS_W-1:0] m;
        m = {1'b0, p[29:14]};
        return neg ? -m : m;
    endfunction

    function automatic logic [usv_pkg::NORM_W-1:0] signed_norm(
            input logic [usv_pkg::MAG_W-1:0] mag, input logic neg);
        logic [usv_pkg::NORM_W-1:0] m;
        m = {1'b0, mag};
        return neg ? -m : m;
    endfunction

    logic [usv_pkg::POS_W-1:0]  r_pos_x, r_pos_y, r_pos_z;
    logic [usv_pkg::NORM_W-1:0] r_norm_x, r_norm_y, r_norm_z;

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_pos_x  <= signed_pos(n_px_p, r_nx_n);
            r_pos_y  <= signed_pos(n_py_p, r_ny_n);
            r_pos_z  <= signed_pos(n_pz_p, r_nz_n);
            r_norm_x <= signed_norm(r_nx_m, r_nx_n);
            r_norm_y <= signed_norm(r_ny_m, r_ny_n);
            r_norm_z <= signed_norm(r_nz_m, r_nz_n);
        end
    end

    assign o_out.valid  = r_v[7];
    assign o_out.pos_x  = r_pos_x;
    assign o_out.pos_y  = r_pos_y;
    assign o_out.pos_z  = r_pos_z;
    assign o_out.norm_x = r_norm_x;
    assign o_out.norm_y = r_norm_y;
    assign o_out.norm_z = r_norm_z;
endmodule

### sv/usv_checker.sv
// port-level assertions for the uv sphere vertex generator
module usv_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic signed [usv_pkg::NORM_W-1:0] i_norm_x,
    input logic signed [usv_pkg::NORM_W-1:0] i_norm_z
);
    // a pending result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // with nothing waiting at the output the block must take requests
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !i_out_valid |-> i_in_ready)
        else $error("request refused with empty output");

    // x and z normal components are unit-bounded
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_norm_x <= 16384) && (i_norm_x >= -16384)
                     && (i_norm_z <= 16384) && (i_norm_z >= -16384))
        else $error("normal out of range");
endmodule

bind uv_sphere_vertex_generator usv_checker u_usv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_norm_x    (o_out.norm_x),
    .i_norm_z    (o_out.norm_z)
);

### dv/uv_sphere_vertex_generator_tb.sv
// self-checking testbench of the uv sphere vertex generator
module uv_sphere_vertex_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  IDX_W      = 10;
    localparam int  CYCLE_CAP  = 400000;
    localparam int  HOLD_LEN   = 150;
    localparam int  DRAIN_WAIT = 12;
    // index 3 is not a register and must be ignored by the block
    localparam logic [1:0] CFG_NONE = 2'd3;

    // one vertex request and one vertex result
    typedef struct packed {
        logic [IDX_W-1:0] stack;
        logic [IDX_W-1:0] sector;
    } t_vtx_req;

    typedef struct packed {
        logic signed [usv_pkg::POS_W-1:0]  px;
        logic signed [usv_pkg::POS_W-1:0]  py;
        logic signed [usv_pkg::POS_W-1:0]  pz;
        logic signed [usv_pkg::NORM_W-1:0] nx;
        logic signed [usv_pkg::NORM_W-1:0] ny;
        logic signed [usv_pkg::NORM_W-1:0] nz;
    } t_vertex;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [usv_pkg::CFG_W-1:0] i_cfg_data;

    usv_in_if #(.INDEX_BITS(IDX_W)) in_if ();
    usv_out_if out_if ();

    uv_sphere_vertex_generator #(.INDEX_BITS(IDX_W), .ANGLE_BITS(16)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // testbench copy of the registers, kept in step with every write
    logic [15:0] radius_q;
    logic [15:0] sector_step_q;
    logic [15:0] stack_step_q;

    t_vtx_req pending_reqs[$];
    t_vertex  vertices_due[$];

    int errors;
    int reqs_taken;
    int vertices_seen;
    int cfg_phases;
    int cycles;

    // ---------------------------------------------------------------
    // vertex predictor
    // ---------------------------------------------------------------

    // sine of x quarter turns, x in q0.16 over [0, 65536], result q1.14
    function automatic longint quarter_sine(longint unsigned x);
        longint unsigned x2, t, s;
        x2 = (x * x) >> 16;
        t  = (64'd4640 * x2) >> 16;
        t  = 64'd42048 - t;
        t  = (t * x2) >> 16;
        t  = 64'd102944 - t;
        s  = (t * x) >> 16;
        s  = (s + 2) >> 2;
        if (s > 16384) s = 16384;
        return longint'(s);
    endfunction

    // quadrant selects which half of the polynomial pair and the sign
    function automatic void angle_sin_cos(input logic [15:0] ang, output longint sn,
                                          output longint cs);
        longint unsigned x;
        longint up, down;
        x    = {ang[13:0], 2'b00};
        up   = quarter_sine(x);
        down = quarter_sine(64'd65536 - x);
        case (ang[15:14])
            2'd0: begin sn = up;    cs = down;  end
            2'd1: begin sn = down;  cs = -up;   end
            2'd2: begin sn = -up;   cs = -down; end
            default: begin sn = -down; cs = up; end
        endcase
    endfunction

    // signed times unsigned, >> 14, round half away from zero on magnitude
    function automatic longint scale_round14(longint a, longint unsigned b);
        longint unsigned m, p;
        m = (a < 0) ? longint'(-a) : longint'(a);
        p = (m * b + 8192) >> 14;
        return (a < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic t_vertex sphere_vertex(logic [IDX_W-1:0] stk,
                                              logic [IDX_W-1:0] sec);
        logic [15:0] stack_ang, sector_ang;
        longint s_st, c_st, s_se, c_se, nx, ny, nz;
        t_vertex v;
        // both angles wrap modulo a full turn
        stack_ang  = 16'(32'd16384 - 32'(stk) * 32'(stack_step_q));
        sector_ang = 16'(32'(sec) * 32'(sector_step_q));
        angle_sin_cos(stack_ang, s_st, c_st);
        angle_sin_cos(sector_ang, s_se, c_se);
        nx = scale_round14(c_st * c_se, 1);
        ny = scale_round14(c_st * s_se, 1);
        nz = s_st;
        v.px = usv_pkg::POS_W'(scale_round14(nx, radius_q));
        v.py = usv_pkg::POS_W'(scale_round14(ny, radius_q));
        v.pz = usv_pkg::POS_W'(scale_round14(nz, radius_q));
        v.nx = usv_pkg::NORM_W'(nx);
        v.ny = usv_pkg::NORM_W'(ny);
        v.nz = usv_pkg::NORM_W'(nz);
        return v;
    endfunction

    // ---------------------------------------------------------------
    // request driver: bursts of random length, random gaps between them
    // ---------------------------------------------------------------
    int       burst_left;
    int       gap_left;
    logic     next_valid;
    t_vtx_req next_req;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            burst_left  = 1;
            gap_left    = 0;
        end else begin
            // a request moves: predict its vertex with the current registers
            if (in_if.valid && in_if.ready) begin
                vertices_due.insert(vertices_due.size(),
                                    sphere_vertex(in_if.stack_index,
                                                  in_if.sector_index));
                reqs_taken++;
            end
            if (!in_if.valid || in_if.ready) begin
                next_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_reqs.size() != 0) begin
                    next_req = pending_reqs.pop_front();
                    in_if.stack_index  <= next_req.stack;
                    in_if.sector_index <= next_req.sector;
                    next_valid = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        // a third of the bursts run straight into the next one
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end
                in_if.valid <= next_valid;
            end
        end
    end

    // ---------------------------------------------------------------
    // long receiver hold-off, counted here so the pipeline backs up
    // ---------------------------------------------------------------
    logic hold_go;
    int   hold_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_go) begin
            hold_left <= HOLD_LEN;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ---------------------------------------------------------------
    // result monitor and receiver stall pattern
    // ---------------------------------------------------------------
    int   stall_mode;
    int   mode_left;
    logic ready_pick;

    task automatic report_mismatch(input string field, input longint got,
                                   input longint want);
        $display("mismatch on vertex %0d field %s: got %0d expected %0d",
                 vertices_seen, field, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_vertex got, want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_mode = 0;
            mode_left  = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got = '{out_if.pos_x, out_if.pos_y, out_if.pos_z,
                        out_if.norm_x, out_if.norm_y, out_if.norm_z};
                if (vertices_due.size() == 0) begin
                    $display("vertex %0d arrived with no request outstanding",
                             vertices_seen);
                    errors++;
                end else begin
                    want = vertices_due.pop_front();
                    if (got.px != want.px) report_mismatch("pos_x", got.px, want.px);
                    if (got.py != want.py) report_mismatch("pos_y", got.py, want.py);
                    if (got.pz != want.pz) report_mismatch("pos_z", got.pz, want.pz);
                    if (got.nx != want.nx) report_mismatch("norm_x", got.nx, want.nx);
                    if (got.ny != want.ny) report_mismatch("norm_y", got.ny, want.ny);
                    if (got.nz != want.nz) report_mismatch("norm_z", got.nz, want.nz);
                end
                vertices_seen++;
            end
            // a new stall pattern is drawn whenever the current one runs out
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(16, 96);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: ready_pick = 1'b1;
                1: ready_pick = 1'($urandom_range(0, 1));
                2: ready_pick = ($urandom_range(0, 3) != 0);
                default: ready_pick = ($urandom_range(0, 7) == 0);
            endcase
            out_if.ready <= (hold_left != 0) ? 1'b0 : ready_pick;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("uv_sphere_vertex_generator regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus sequence
    // ---------------------------------------------------------------
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            usv_pkg::CFG_RADIUS:      radius_q      = val;
            usv_pkg::CFG_SECTOR_STEP: sector_step_q = val;
            usv_pkg::CFG_STACK_STEP:  stack_step_q  = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // block is idle: nothing queued, nothing offered, nothing outstanding
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || in_if.valid || vertices_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [15:0] rad, input logic [15:0] sec,
                            input logic [15:0] stk);
        wait_idle();
        write_reg(usv_pkg::CFG_RADIUS, rad);
        write_reg(usv_pkg::CFG_SECTOR_STEP, sec);
        write_reg(usv_pkg::CFG_STACK_STEP, stk);
        cfg_phases++;
    endtask

    task automatic queue_req(input int stk, input int sec);
        t_vtx_req r;
        r = '{IDX_W'(stk), IDX_W'(sec)};
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    initial begin
        int rings, cols, n;
        logic [15:0] rad;
        // known values before the first edge
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = usv_pkg::CFG_RADIUS;
        i_cfg_data  = '0;
        in_if.valid        = 1'b0;
        in_if.stack_index  = '0;
        in_if.sector_index = '0;
        out_if.ready       = 1'b0;
        hold_go       = 1'b0;
        errors        = 0;
        reqs_taken    = 0;
        vertices_seen = 0;
        cfg_phases    = 0;
        cycles        = 0;
        radius_q      = 16'd1638;
        sector_step_q = 16'd303;
        stack_step_q  = 16'd303;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: poles, equator, index extremes
        queue_req(0, 0);
        queue_req(1023, 1023);
        queue_req(0, 1023);
        queue_req(1023, 0);
        queue_req(54, 216);
        queue_req(108, 108);
        queue_req(512, 341);

        // zero steps hold both angles, zero radius clears the positions
        set_regs(16'd0, 16'd0, 16'd0);
        queue_req(0, 0);
        queue_req(1023, 1023);
        queue_req(517, 3);

        // largest registers: angles wrap on every step
        set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_req(0, 0);
        queue_req(1, 1);
        queue_req(1023, 1023);
        queue_req(682, 341);

        // a write beyond the last register must change nothing
        set_regs(16'd1, 16'd16384, 16'd8192);
        write_reg(CFG_NONE, 16'hFFFF);
        queue_req(0, 1);
        queue_req(1, 2);
        queue_req(2, 3);
        queue_req(4, 1023);
        queue_req(3, 0);
        queue_req(1023, 512);

        // random phases: mostly whole-sphere sweeps with random content
        for (int phase = 0; phase < 5; phase++) begin
            case ($urandom_range(0, 3))
                0: rad = 16'd1;
                1: rad = 16'hFFFF;
                2: rad = 16'd4096;
                default: rad = 16'($urandom_range(1, 65535));
            endcase
            rings = $urandom_range(2, 40);
            cols  = $urandom_range(3, 64);
            if ($urandom_range(0, 3) == 0)
                set_regs(rad, 16'($urandom_range(1, 65535)),
                         16'($urandom_range(1, 65535)));
            else
                set_regs(rad, 16'(65536 / cols), 16'(32768 / rings));
            if (phase == 0) begin
                // long receiver stall while requests keep coming
                @(posedge i_clk);
                hold_go <= 1'b1;
                @(posedge i_clk);
                hold_go <= 1'b0;
            end
            n = 0;
            while (n < 100) begin
                if ($urandom_range(0, 4) != 0) begin
                    queue_req($urandom_range(0, rings), $urandom_range(0, cols));
                end else begin
                    queue_req($urandom_range(0, 1023), $urandom_range(0, 1023));
                end
                n++;
            end
        end

        wait_idle();
        $display("covered %0d vertex requests and %0d results over %0d register settings",
                 reqs_taken, vertices_seen, cfg_phases + 1);
        $display("settings spanned zero and full-scale radius and steps, with back-pressure");
        if (errors == 0)
            $display("uv_sphere_vertex_generator regression: pass");
        else
            $display("uv_sphere_vertex_generator regression: fail");
        $finish;
    end

endmodule
